/* hw/rtl/uyvy_to_argb_converter_defines.svh */
// assertion helpers for the uyvy to argb converter
`ifndef UYVY_TO_ARGB_CONVERTER_DEFINES_SVH
`define UYVY_TO_ARGB_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UY2A_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uy2a check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define UY2A_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uy2a check failed: next-cycle rule");

`endif

/* hw/rtl/uy2a_pkg.sv */
package uy2a_pkg;

  localparam int CHAN_W = 8;
  localparam int PROD_W = 27;
  localparam int SUM_W  = 28;
  localparam int FRAC_W = 16;

  localparam logic signed [18:0] COEF_Y       = 19'sd76309;
  localparam logic signed [18:0] COEF_U_BLUE  = 19'sd132201;
  localparam logic signed [18:0] COEF_U_GREEN = -19'sd25674;
  localparam logic signed [18:0] COEF_V_GREEN = -19'sd53278;
  localparam logic signed [18:0] COEF_V_RED   = 19'sd104597;

  localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE  = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_MAX      = 8'hFF;

  typedef struct packed {
    logic signed [PROD_W-1:0] red;
    logic signed [PROD_W-1:0] green_u;
    logic signed [PROD_W-1:0] green_v;
    logic signed [PROD_W-1:0] blue;
  } chroma_terms_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // advance strobes for the three pipeline stages
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } pipe_ctrl_t;

  // floor shift by 16 then limit to 0..255
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
    logic [CHAN_W-1:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (|s[SUM_W-2:FRAC_W+CHAN_W]) begin
      res = CHAN_MAX;
    end else begin
      res = s[FRAC_W+CHAN_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/uy2a_chroma_terms.sv */
module uy2a_chroma_terms (
  input  logic                    clk,
  input  uy2a_pkg::pipe_ctrl_t    ctrl,
  input  logic [7:0]              cb_sample,
  input  logic [7:0]              cr_sample,
  output uy2a_pkg::chroma_terms_t terms
);
  import uy2a_pkg::*;

  logic signed [8:0] ue;
  logic signed [8:0] ve;

  assign ue = $signed({1'b0, cb_sample}) - CHROMA_OFFSET;
  assign ve = $signed({1'b0, cr_sample}) - CHROMA_OFFSET;

  // chroma products are shared by both pixel lanes
  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      terms.red     <= PROD_W'(COEF_V_RED) * PROD_W'(ve);
      terms.green_u <= PROD_W'(COEF_U_GREEN) * PROD_W'(ue);
      terms.green_v <= PROD_W'(COEF_V_GREEN) * PROD_W'(ve);
      terms.blue    <= PROD_W'(COEF_U_BLUE) * PROD_W'(ue);
    end
  end

endmodule

/* hw/rtl/uy2a_pixel_lane.sv */
module uy2a_pixel_lane (
  input  logic                    clk,
  input  uy2a_pkg::pipe_ctrl_t    ctrl,
  input  logic [7:0]              luma,
  input  uy2a_pkg::chroma_terms_t terms,
  output uy2a_pkg::pixel_t        pixel
);
  import uy2a_pkg::*;

  logic signed [8:0]        luma_off;
  logic signed [PROD_W-1:0] ye;
  logic signed [SUM_W-1:0]  red_sum;
  logic signed [SUM_W-1:0]  green_sum;
  logic signed [SUM_W-1:0]  blue_sum;

  assign luma_off = $signed({1'b0, luma}) - LUMA_OFFSET;

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) begin
      ye <= PROD_W'(COEF_Y) * PROD_W'(luma_off);
    end
  end

  assign red_sum   = SUM_W'(ye) + SUM_W'(terms.red);
  assign green_sum = SUM_W'(ye) + SUM_W'(terms.green_u) + SUM_W'(terms.green_v);
  assign blue_sum  = SUM_W'(ye) + SUM_W'(terms.blue);

  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      pixel.red   <= clamp_chan(red_sum);
      pixel.green <= clamp_chan(green_sum);
      pixel.blue  <= clamp_chan(blue_sum);
    end
  end

endmodule

/* hw/rtl/uy2a_out_merge.sv */
module uy2a_out_merge (
  input  logic                 clk,
  input  uy2a_pkg::pipe_ctrl_t ctrl,
  input  uy2a_pkg::pixel_t     pixel_first,
  input  uy2a_pkg::pixel_t     pixel_second,
  input  logic                 line_end,
  output logic [55:0]          tdata,
  output logic                 tlast
);
  import uy2a_pkg::*;

  // output register joins both lanes into one argb pair
  always_ff @(posedge clk) begin
    if (ctrl.s3_en) begin
      tdata <= {ALPHA_OPAQUE,
                pixel_second.blue, pixel_second.green, pixel_second.red,
                pixel_first.blue, pixel_first.green, pixel_first.red};
      tlast <= line_end;
    end
  end

endmodule

/* hw/rtl/uyvy_to_argb_converter.sv */
// UYVY 4:2:2 to ARGB converter, studio-range BT.601 in 16-bit fixed point.
// Each input transfer carries one macropixel and yields one output transfer
// holding two RGB pixels with alpha 255; tlast is carried along unchanged.
// A new macropixel is taken every cycle unless the output stalls. The stages
// are the multiply stage (one luma product per lane plus the shared chroma
// products), the sum-and-clamp stage in each of the two pixel lanes, and
// the output register. Each stage holds its data only while the stage
// after it is full and stalled, so bubbles are squeezed out under backpressure.
module uyvy_to_argb_converter (
  input  logic        clk,
  input  logic        rst,
  // cb_sample[7:0], luma_first[15:8], cr_sample[23:16], luma_second[31:24]
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  input  logic        s_tvalid,
  output logic        s_tready,
  // red_first, green_first, blue_first, red_second, green_second,
  // blue_second, alpha_value: 8 bits each from bit 0 up
  output logic [55:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tvalid,
  input  logic        m_tready
);
  import uy2a_pkg::*;

`include "uyvy_to_argb_converter_defines.svh"

  pipe_ctrl_t    ctrl;
  chroma_terms_t terms;
  pixel_t        pixel_first;
  pixel_t        pixel_second;
  logic          s1_valid;
  logic          s2_valid;
  logic          line_end_s1;
  logic          line_end_s2;

  // a stage moves when it is empty or the one after it moves
  assign ctrl.s3_en = !m_tvalid || m_tready;
  assign ctrl.s2_en = !s2_valid || ctrl.s3_en;
  assign ctrl.s1_en = !s1_valid || ctrl.s2_en;
  assign s_tready   = ctrl.s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctrl.s1_en) s1_valid <= s_tvalid;
      if (ctrl.s2_en) s2_valid <= s1_valid;
      if (ctrl.s3_en) m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) line_end_s1 <= s_tlast;
    if (ctrl.s2_en) line_end_s2 <= line_end_s1;
  end

  uy2a_chroma_terms u_chroma (
    .clk       (clk),
    .ctrl      (ctrl),
    .cb_sample (s_tdata[7:0]),
    .cr_sample (s_tdata[23:16]),
    .terms     (terms)
  );

  uy2a_pixel_lane u_lane_first (
    .clk   (clk),
    .ctrl  (ctrl),
    .luma  (s_tdata[15:8]),
    .terms (terms),
    .pixel (pixel_first)
  );

  uy2a_pixel_lane u_lane_second (
    .clk   (clk),
    .ctrl  (ctrl),
    .luma  (s_tdata[31:24]),
    .terms (terms),
    .pixel (pixel_second)
  );

  uy2a_out_merge u_merge (
    .clk          (clk),
    .ctrl         (ctrl),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .line_end     (line_end_s2),
    .tdata        (m_tdata),
    .tlast        (m_tlast)
  );

  // a free output slot must never block the input
  `UY2A_ASSERT_NOW(a_ready_when_drained, clk, rst, m_tready, s_tready)

  // a full first stage that cannot move must stall the input
  `UY2A_ASSERT_NOW(a_stall_backs_up, clk, rst, s1_valid && !ctrl.s2_en, !s_tready)

  // an accepted transfer with an open path reaches the first stage
  `UY2A_ASSERT_NEXT(a_stage_fill, clk, rst, s_tvalid && s_tready, s1_valid)

  // every result carries an opaque alpha
  `UY2A_ASSERT_NOW(a_alpha_opaque, clk, rst, m_tvalid, m_tdata[55:48] == ALPHA_OPAQUE)

endmodule
